[hw/rtl/smx_pkg.sv]
package smx_pkg;

   // machine word
   localparam int WORD_W = 32;

   // opcodes
   localparam logic [3:0] OP_NOP = 4'd0;
   localparam logic [3:0] OP_LDI = 4'd1;
   localparam logic [3:0] OP_OUT = 4'd2;
   localparam logic [3:0] OP_ADD = 4'd3;
   localparam logic [3:0] OP_SUB = 4'd4;
   localparam logic [3:0] OP_MUL = 4'd5;
   localparam logic [3:0] OP_DVM = 4'd6;
   localparam logic [3:0] OP_DUP = 4'd7;
   localparam logic [3:0] OP_POP = 4'd8;
   localparam logic [3:0] OP_SWP = 4'd9;
   localparam logic [3:0] OP_JMP = 4'd10;
   localparam logic [3:0] OP_BNZ = 4'd11;
   localparam logic [3:0] OP_LAB = 4'd12;
   localparam logic [3:0] OP_END = 4'd13;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVER  = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   // command to the shared divider
   typedef struct packed {
      logic start;
      logic signed_mode;
   } smx_div_cmd_type;

endpackage

[hw/rtl/smx_ram.sv]
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/smx_divider.sv]
module smx_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  smx_pkg::smx_div_cmd_type        cmd,
   input  logic [smx_pkg::WORD_W-1:0]      dividend,
   input  logic [smx_pkg::WORD_W-1:0]      divisor,
   output logic                            done,
   output logic [smx_pkg::WORD_W-1:0]      quotient,
   output logic [smx_pkg::WORD_W-1:0]      remainder
);

   localparam int W     = smx_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIX  = 3'b100
   } div_state_type;

   div_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic             negq_ff, negq_in;
   logic             negr_ff, negr_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;

   // one restoring step per cycle
   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               negq_in  = cmd.signed_mode & (dividend[W-1] ^ divisor[W-1]);
               negr_in  = cmd.signed_mode & dividend[W-1];
               quo_in   = (cmd.signed_mode && dividend[W-1]) ? (W'(0) - dividend) : dividend;
               dvs_in   = (cmd.signed_mode && divisor[W-1]) ? (W'(0) - divisor) : divisor;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!trial[W]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W - 1)) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            quo_in   = negq_ff ? (W'(0) - quo_ff) : quo_ff;
            rem_in   = negr_ff ? (W'(0) - rem_ff) : rem_ff;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/stack_machine_executor_unit.sv]
// nop, ldi, pop, end and undivided lab answer from dispatch, out, dup, jmp and bnz from the top state;
// add, sub, mul, swp and divmod also read the word beneath; divmod then runs on the 32-step shared divider
// jmp, bnz, lab divide unless LABEL_COUNT is a power of two; lab also unless PROGRAM_SIZE is
// throughput: one request at a time, next request taken the cycle after the response leaves
// reset: synchronous, empties the stack and invalidates all labels; no memory clearing pass,
// stack cells are always pushed before they are read
module stack_machine_executor_unit #(
   parameter int STACK_DEPTH  = 4096,
   parameter int LABEL_COUNT  = 256,
   parameter int PROGRAM_SIZE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [30:0] req_immediate,
   input  logic [15:0] req_instr_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_redirect,
   output logic [15:0] rsp_next_index,
   output logic        rsp_halted,
   output logic [1:0]  rsp_status
);

   localparam int W     = smx_pkg::WORD_W;
   localparam int SP_W  = $clog2(STACK_DEPTH);
   localparam int LBL_W = $clog2(LABEL_COUNT);

   // label number and label target reduce by mask when the sizes are powers of two
   localparam bit LBL_POW2  = (LABEL_COUNT & (LABEL_COUNT - 1)) == 0;
   localparam bit PROG_POW2 = (PROGRAM_SIZE & (PROGRAM_SIZE - 1)) == 0;

   localparam logic [SP_W-1:0] SP_EMPTY = SP_W'(STACK_DEPTH - 1);
   localparam logic [SP_W-1:0] SP_ONE   = SP_W'(STACK_DEPTH - 2);
   localparam logic [16:0]     PROG_MSK = 17'(PROGRAM_SIZE - 1);

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,  // waiting for a request
      S_LDIV     = 8'b0000_0010,  // label number modulo label count on the divider
      S_DISPATCH = 8'b0000_0100,  // checks, ops that answer from here, first read issued
      S_TOP      = 8'b0000_1000,  // top word (and label entry) available
      S_BOTH     = 8'b0001_0000,  // second word available, arithmetic
      S_DIV      = 8'b0010_0000,  // divmod or label target on the divider
      S_WR2      = 8'b0100_0000,  // second stack write
      S_RSP      = 8'b1000_0000   // response held until taken
   } state_type;

   state_type state_ff, state_in;

   // request held for the whole instruction
   logic [3:0]       op_ff, op_in;
   logic [30:0]      imm_ff, imm_in;
   logic [15:0]      idx_ff, idx_in;
   logic [LBL_W-1:0] lbl_ff, lbl_in;

   // machine state
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic                   halt_ff, halt_in;
   logic [LABEL_COUNT-1:0] lab_vld_ff, lab_vld_in;

   // operands held across cycles
   logic [W-1:0] t_ff, t_in;
   logic [W-1:0] wr2_ff, wr2_in;

   // response register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        redirect_ff, redirect_in;
   logic [15:0] next_ff, next_in;
   logic [1:0]  status_ff, status_in;

   // stack memory ports
   logic            stk_we;
   logic [SP_W-1:0] stk_waddr;
   logic [W-1:0]    stk_wdata;
   logic [SP_W-1:0] stk_raddr;
   logic [W-1:0]    stk_rdata;

   // label memory ports, both addressed by the held label number
   logic        lab_we;
   logic [15:0] lab_wdata;
   logic [15:0] lab_rdata;
   logic [15:0] lab_target;

   // shared divider
   smx_pkg::smx_div_cmd_type div_cmd;
   logic [W-1:0] div_a;
   logic [W-1:0] div_b;
   logic         div_done;
   logic [W-1:0] div_quo;
   logic [W-1:0] div_rem;

   logic [16:0]     idx_inc;
   logic [SP_W-1:0] sp_up;
   logic [SP_W-1:0] sp_dn;
   logic            lbl_op;

   assign idx_inc = {1'b0, idx_ff} + 17'd1;
   assign sp_up   = sp_ff + SP_W'(1);
   assign sp_dn   = sp_ff - SP_W'(1);

   // a label never defined reads as instruction 0
   assign lab_target = lab_vld_ff[lbl_ff] ? lab_rdata : 16'd0;

   assign lbl_op = (req_type == smx_pkg::OP_JMP) || (req_type == smx_pkg::OP_BNZ)
                || (req_type == smx_pkg::OP_LAB);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      idx_in       = idx_ff;
      lbl_in       = lbl_ff;
      sp_in        = sp_ff;
      halt_in      = halt_ff;
      lab_vld_in   = lab_vld_ff;
      t_in         = t_ff;
      wr2_in       = wr2_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      redirect_in  = redirect_ff;
      next_in      = next_ff;
      status_in    = status_ff;
      stk_we       = 1'b0;
      stk_waddr    = sp_ff;
      stk_wdata    = t_ff;
      stk_raddr    = sp_ff;
      lab_we       = 1'b0;
      lab_wdata    = 16'(idx_inc & PROG_MSK);
      div_cmd      = '0;
      div_a        = stk_rdata;
      div_b        = t_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_type;
               imm_in       = req_immediate;
               idx_in       = req_instr_index;
               lbl_in       = req_immediate[LBL_W-1:0];
               out_valid_in = 1'b0;
               out_char_in  = 8'd0;
               redirect_in  = 1'b0;
               next_in      = 16'd0;
               status_in    = smx_pkg::ST_OK;
               if (!LBL_POW2 && !halt_ff && lbl_op) begin
                  // label number is the immediate modulo the label count
                  div_cmd.start = 1'b1;
                  div_a         = {1'b0, req_immediate};
                  div_b         = W'(LABEL_COUNT);
                  state_in      = S_LDIV;
               end else begin
                  state_in = S_DISPATCH;
               end
            end
         end

         S_LDIV: begin
            if (div_done) begin
               lbl_in   = div_rem[LBL_W-1:0];
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in = S_RSP;
            if (!halt_ff) begin
               unique case (op_ff)
                  smx_pkg::OP_LDI: begin
                     if (sp_ff == '0) begin
                        status_in = smx_pkg::ST_OVER;
                     end else begin
                        stk_we    = 1'b1;
                        stk_waddr = sp_dn;
                        stk_wdata = {1'b0, imm_ff};
                        sp_in     = sp_dn;
                     end
                  end
                  smx_pkg::OP_DUP: begin
                     if (sp_ff == SP_EMPTY) begin
                        status_in = smx_pkg::ST_UNDER;
                     end else if (sp_ff == '0) begin
                        status_in = smx_pkg::ST_OVER;
                     end else begin
                        state_in = S_TOP;
                     end
                  end
                  smx_pkg::OP_OUT,
                  smx_pkg::OP_BNZ: begin
                     if (sp_ff == SP_EMPTY) begin
                        status_in = smx_pkg::ST_UNDER;
                     end else begin
                        state_in = S_TOP;
                     end
                  end
                  smx_pkg::OP_POP: begin
                     if (sp_ff == SP_EMPTY) begin
                        status_in = smx_pkg::ST_UNDER;
                     end else begin
                        sp_in = sp_up;
                     end
                  end
                  smx_pkg::OP_ADD,
                  smx_pkg::OP_SUB,
                  smx_pkg::OP_MUL,
                  smx_pkg::OP_DVM,
                  smx_pkg::OP_SWP: begin
                     // fewer than two words on the stack
                     if (sp_ff >= SP_ONE) begin
                        status_in = smx_pkg::ST_UNDER;
                     end else begin
                        state_in = S_TOP;
                     end
                  end
                  smx_pkg::OP_JMP: begin
                     state_in = S_TOP;
                  end
                  smx_pkg::OP_LAB: begin
                     if (PROG_POW2) begin
                        lab_we             = 1'b1;
                        lab_vld_in[lbl_ff] = 1'b1;
                     end else begin
                        // label target is the next index modulo the program size
                        div_cmd.start = 1'b1;
                        div_a         = W'(idx_inc);
                        div_b         = W'(PROGRAM_SIZE);
                        state_in      = S_DIV;
                     end
                  end
                  smx_pkg::OP_END: begin
                     halt_in = 1'b1;
                  end
                  default: begin
                     // nop and unused opcodes
                  end
               endcase
            end
         end

         S_TOP: begin
            state_in = S_RSP;
            unique case (op_ff)
               smx_pkg::OP_DUP: begin
                  stk_we    = 1'b1;
                  stk_waddr = sp_dn;
                  stk_wdata = stk_rdata;
                  sp_in     = sp_dn;
               end
               smx_pkg::OP_OUT: begin
                  out_valid_in = 1'b1;
                  out_char_in  = stk_rdata[7:0];
                  sp_in        = sp_up;
               end
               smx_pkg::OP_BNZ: begin
                  if (stk_rdata != '0) begin
                     redirect_in = 1'b1;
                     next_in     = lab_target;
                  end
               end
               smx_pkg::OP_JMP: begin
                  redirect_in = 1'b1;
                  next_in     = lab_target;
               end
               default: begin
                  // two-operand ops fetch the word beneath
                  t_in      = stk_rdata;
                  stk_raddr = sp_up;
                  state_in  = S_BOTH;
               end
            endcase
         end

         S_BOTH: begin
            state_in  = S_RSP;
            stk_waddr = sp_up;
            unique case (op_ff)
               smx_pkg::OP_ADD: begin
                  stk_we    = 1'b1;
                  stk_wdata = stk_rdata + t_ff;
                  sp_in     = sp_up;
               end
               smx_pkg::OP_SUB: begin
                  stk_we    = 1'b1;
                  stk_wdata = stk_rdata - t_ff;
                  sp_in     = sp_up;
               end
               smx_pkg::OP_MUL: begin
                  stk_we    = 1'b1;
                  stk_wdata = stk_rdata * t_ff;
                  sp_in     = sp_up;
               end
               smx_pkg::OP_SWP: begin
                  stk_we    = 1'b1;
                  stk_wdata = t_ff;
                  wr2_in    = stk_rdata;
                  state_in  = S_WR2;
               end
               smx_pkg::OP_DVM: begin
                  if (t_ff == '0) begin
                     status_in = smx_pkg::ST_DIVZ;
                  end else begin
                     div_cmd.start       = 1'b1;
                     div_cmd.signed_mode = 1'b1;
                     state_in            = S_DIV;
                  end
               end
               default: begin
               end
            endcase
         end

         S_DIV: begin
            if (div_done) begin
               if (op_ff == smx_pkg::OP_LAB) begin
                  lab_we             = 1'b1;
                  lab_wdata          = div_rem[15:0];
                  lab_vld_in[lbl_ff] = 1'b1;
                  state_in           = S_RSP;
               end else begin
                  // remainder beneath, quotient on top
                  stk_we    = 1'b1;
                  stk_waddr = sp_up;
                  stk_wdata = div_rem;
                  wr2_in    = div_quo;
                  state_in  = S_WR2;
               end
            end
         end

         S_WR2: begin
            stk_we    = 1'b1;
            stk_waddr = sp_ff;
            stk_wdata = wr2_ff;
            state_in  = S_RSP;
         end

         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         sp_ff      <= SP_EMPTY;
         halt_ff    <= 1'b0;
         lab_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         halt_ff    <= halt_in;
         lab_vld_ff <= lab_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      imm_ff       <= imm_in;
      idx_ff       <= idx_in;
      lbl_ff       <= lbl_in;
      t_ff         <= t_in;
      wr2_ff       <= wr2_in;
      out_valid_ff <= out_valid_in;
      out_char_ff  <= out_char_in;
      redirect_ff  <= redirect_in;
      next_ff      <= next_in;
      status_ff    <= status_in;
   end

   // stack memory, grows downward; the highest cell marks the empty stack and is never written
   smx_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // label table
   smx_ram #(
      .WIDTH (16),
      .DEPTH (LABEL_COUNT)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lab_we),
      .wr_addr (lbl_ff),
      .wr_data (lab_wdata),
      .rd_addr (lbl_ff),
      .rd_data (lab_rdata)
   );

   // shared bit-serial divider
   smx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_RSP);
   assign rsp_out_valid  = out_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_redirect   = redirect_ff;
   assign rsp_next_index = next_ff;
   assign rsp_halted     = halt_ff;
   assign rsp_status     = status_ff;

endmodule

[hw/rtl/smx_checker.sv]
module smx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_out_valid,
   input logic        rsp_redirect,
   input logic        rsp_halted,
   input logic [1:0]  rsp_status
);

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("still ready after taking a request");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("not ready after response left");

   // a failed instruction has no side outputs
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != smx_pkg::ST_OK)) |-> (!rsp_out_valid && !rsp_redirect))
      else $error("error response carries a char or redirect");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_halted |=> rsp_halted)
      else $error("halt flag dropped");

endmodule

bind stack_machine_executor_unit smx_checker u_smx_checker (.*);
